// File: rtl/core/tmq_pkg.sv
// ----------------------------------------------------------------------------
// tmq_pkg
// Shared widths, status codes, register indexes and reset values for the
// timestamp match queue.
// ----------------------------------------------------------------------------
package tmq_pkg;

    localparam int STAMP_W    = 63;
    localparam int HANDLE_W   = 16;
    localparam int STATUS_W   = 3;
    localparam int HELD_W     = 10;
    localparam int LIMIT_W    = 10;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;
    localparam int GAP_W      = 32;

    localparam int DEFAULT_QUEUE_DEPTH = 512;

    typedef logic [STATUS_W-1:0]   status_t;
    typedef logic [STAMP_W-1:0]    stamp_t;
    typedef logic [HANDLE_W-1:0]   handle_t;
    typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
    typedef logic [CFG_DATA_W-1:0] cfg_data_t;

    localparam status_t ST_STORED       = 3'd0;
    localparam status_t ST_STORED_DROP  = 3'd1;
    localparam status_t ST_LANE_SOON    = 3'd2;
    localparam status_t ST_VIDEO_SOON   = 3'd3;
    localparam status_t ST_MATCHED      = 3'd4;
    localparam status_t ST_EMPTY        = 3'd5;
    localparam status_t ST_TOO_FAR      = 3'd6;
    localparam status_t ST_NONE_EARLIER = 3'd7;

    localparam logic CMD_LANE  = 1'b0;
    localparam logic CMD_VIDEO = 1'b1;

    localparam cfg_idx_t REG_LANE_GAP    = 8'd0;
    localparam cfg_idx_t REG_VIDEO_GAP   = 8'd1;
    localparam cfg_idx_t REG_MATCH_WIN   = 8'd2;
    localparam cfg_idx_t REG_QUEUE_LIMIT = 8'd3;

    localparam logic [GAP_W-1:0]   RST_LANE_GAP    = 32'd50000000;
    localparam logic [GAP_W-1:0]   RST_VIDEO_GAP   = 32'd5000000;
    localparam logic [GAP_W-1:0]   RST_MATCH_WIN   = 32'd300000000;
    localparam logic [LIMIT_W-1:0] RST_QUEUE_LIMIT = 10'd500;

endpackage

// File: rtl/core/tmq_in_if.sv
// ----------------------------------------------------------------------------
// tmq_in_if
// Request channel into the queue: lane store or video match request.
// ----------------------------------------------------------------------------
interface tmq_in_if;
    import tmq_pkg::*;

    logic    valid;
    logic    ready;
    logic    command;
    stamp_t  stamp_ns;
    handle_t payload_handle;

    modport source (output valid, output command, output stamp_ns,
                    output payload_handle, input ready);
    modport sink   (input valid, input command, input stamp_ns,
                    input payload_handle, output ready);
endinterface

// File: rtl/core/tmq_out_if.sv
// ----------------------------------------------------------------------------
// tmq_out_if
// Result channel out of the queue: one result per request.
// ----------------------------------------------------------------------------
interface tmq_out_if;
    import tmq_pkg::*;

    logic              valid;
    logic              ready;
    status_t           status;
    handle_t           match_handle;
    stamp_t            match_stamp_ns;
    logic [HELD_W-1:0] entries_held;

    modport source (output valid, output status, output match_handle,
                    output match_stamp_ns, output entries_held, input ready);
    modport sink   (input valid, input status, input match_handle,
                    input match_stamp_ns, input entries_held, output ready);
endinterface

// File: rtl/core/tmq_cfg_if.sv
// ----------------------------------------------------------------------------
// tmq_cfg_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface tmq_cfg_if;
    import tmq_pkg::*;

    logic      valid;
    logic      ready;
    cfg_idx_t  index;
    cfg_data_t data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/timestamp_match_queue.sv
// ----------------------------------------------------------------------------
// timestamp_match_queue
// Time-ordered circular queue of lane handles, matched against video frames.
// ----------------------------------------------------------------------------
// A request takes one at a time through a small sequencer built around one
// 64-bit subtractor, one 32-bit threshold compare and one single-port queue
// memory with a registered read. Each request passes the difference and gate
// states; a too-soon request or a frame on an empty queue then goes to done,
// a stored lane item through store. A searched video frame runs probe and
// compare steps, then pick, fetch and window, stopping at pick when no entry
// lies at or before the frame: each search step is one memory read followed
// by one subtract. The result sits in an output register, so the next request
// is taken while it waits; a result still held when the next one is ready
// stalls the sequencer. The queue memory needs no clearing after reset.
module timestamp_match_queue
#(
    parameter int QUEUE_DEPTH = tmq_pkg::DEFAULT_QUEUE_DEPTH
)
(
    input  logic   clk,
    input  logic   rst_n,
    tmq_in_if.sink   item,
    tmq_out_if.source result,
    tmq_cfg_if.sink  cfg
);
    import tmq_pkg::*;

    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;
    localparam int MW = STAMP_W + HANDLE_W;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DIFF  = 4'd1;
    localparam logic [3:0] S_GATE  = 4'd2;
    localparam logic [3:0] S_STORE = 4'd3;
    localparam logic [3:0] S_PROBE = 4'd4;
    localparam logic [3:0] S_CMP   = 4'd5;
    localparam logic [3:0] S_PICK  = 4'd6;
    localparam logic [3:0] S_FETCH = 4'd7;
    localparam logic [3:0] S_WIN   = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    // control state
    logic [3:0]         state_reg, state_next;
    logic [IW-1:0]      oldest_reg, oldest_next;
    logic [CW-1:0]      total_reg, total_next;
    logic [CW-1:0]      lo_reg, lo_next;
    logic [CW-1:0]      hi_reg, hi_next;
    stamp_t             last_lane_reg, last_lane_next;
    stamp_t             last_video_reg, last_video_next;
    logic               out_valid_reg, out_valid_next;
    logic [GAP_W-1:0]   lane_gap_reg, video_gap_reg, window_reg;
    logic [LIMIT_W-1:0] limit_reg;

    // request and working payload
    logic               cmd_reg, cmd_next;
    stamp_t             stamp_reg, stamp_next;
    handle_t            handle_reg, handle_next;
    logic [63:0]        diff_reg, diff_next;
    status_t            status_reg, status_next;
    handle_t            res_handle_reg, res_handle_next;
    stamp_t             res_stamp_reg, res_stamp_next;

    // output register
    status_t            out_status_reg;
    handle_t            out_handle_reg;
    stamp_t             out_stamp_reg;
    logic [HELD_W-1:0]  out_held_reg;
    logic               out_load;

    // queue memory
    logic [MW-1:0]      mem [QUEUE_DEPTH];
    logic [MW-1:0]      rd_reg;
    logic               mem_we, mem_re;
    stamp_t             rd_stamp;
    handle_t            rd_handle;

    // shared units
    stamp_t             sub_b;
    logic [63:0]        sub_res;
    logic [GAP_W-1:0]   thresh;
    logic               below;
    logic [CW-1:0]      offset;
    logic [CW:0]        slot_sum;
    logic [IW-1:0]      slot;
    logic [CW-1:0]      mid;
    logic [LW-1:0]      eff_limit;
    logic [LW-1:0]      limit_ext;

    assign rd_stamp  = rd_reg[MW-1:HANDLE_W];
    assign rd_handle = rd_reg[HANDLE_W-1:0];

    assign item.ready = (state_reg == S_IDLE);
    assign cfg.ready  = 1'b1;

    assign result.valid          = out_valid_reg;
    assign result.status         = out_status_reg;
    assign result.match_handle   = out_handle_reg;
    assign result.match_stamp_ns = out_stamp_reg;
    assign result.entries_held   = out_held_reg;

    // one subtractor: rate gap, search compare and match distance
    always_comb
    begin
        if (state_reg == S_DIFF)
        begin
            sub_b = (cmd_reg == CMD_VIDEO) ? last_video_reg : last_lane_reg;
        end
        else
        begin
            sub_b = rd_stamp;
        end
        sub_res = {1'b0, stamp_reg} - {1'b0, sub_b};
    end

    always_comb
    begin
        if (state_reg == S_WIN)
        begin
            thresh = window_reg;
        end
        else
        begin
            thresh = (cmd_reg == CMD_VIDEO) ? video_gap_reg : lane_gap_reg;
        end
        below = (diff_reg[STAMP_W-1:0] < {{(STAMP_W-GAP_W){1'b0}}, thresh});
    end

    assign mid = lo_reg + ((hi_reg - lo_reg) >> 1);

    // circular slot of an offset from the oldest entry
    always_comb
    begin
        case (state_reg)
            S_GATE:  offset = CW'(1);
            S_STORE: offset = total_reg;
            S_PROBE: offset = mid;
            S_PICK:  offset = lo_reg - CW'(1);
            S_WIN:   offset = lo_reg;
            default: offset = '0;
        endcase
        slot_sum = (CW+1)'(oldest_reg) + (CW+1)'(offset);
        if (slot_sum >= (CW+1)'(QUEUE_DEPTH))
        begin
            slot = IW'(slot_sum - (CW+1)'(QUEUE_DEPTH));
        end
        else
        begin
            slot = IW'(slot_sum);
        end
    end

    always_comb
    begin
        limit_ext = LW'(limit_reg);
        if (limit_ext == '0)
        begin
            eff_limit = LW'(1);
        end
        else if (limit_ext > LW'(QUEUE_DEPTH))
        begin
            eff_limit = LW'(QUEUE_DEPTH);
        end
        else
        begin
            eff_limit = limit_ext;
        end
    end

    assign mem_we = (state_reg == S_STORE);
    assign mem_re = (state_reg == S_PROBE) || (state_reg == S_PICK);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[slot] <= {stamp_reg, handle_reg};
        end
        if (mem_re)
        begin
            rd_reg <= mem[slot];
        end
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        oldest_next     = oldest_reg;
        total_next      = total_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        last_lane_next  = last_lane_reg;
        last_video_next = last_video_reg;
        cmd_next        = cmd_reg;
        stamp_next      = stamp_reg;
        handle_next     = handle_reg;
        diff_next       = diff_reg;
        status_next     = status_reg;
        res_handle_next = res_handle_reg;
        res_stamp_next  = res_stamp_reg;
        out_load        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (item.valid)
                begin
                    cmd_next        = item.command;
                    stamp_next      = item.stamp_ns;
                    handle_next     = item.payload_handle;
                    res_handle_next = '0;
                    res_stamp_next  = '0;
                    state_next      = S_DIFF;
                end
            end
            S_DIFF:
            begin
                diff_next  = sub_res;
                state_next = S_GATE;
            end
            S_GATE:
            begin
                if (diff_reg[63] || below)
                begin
                    status_next = (cmd_reg == CMD_VIDEO) ? ST_VIDEO_SOON : ST_LANE_SOON;
                    state_next  = S_DONE;
                end
                else if (cmd_reg == CMD_LANE)
                begin
                    last_lane_next = stamp_reg;
                    status_next    = ST_STORED;
                    if (LW'(total_reg) >= eff_limit)
                    begin
                        oldest_next = slot;
                        total_next  = total_reg - CW'(1);
                        status_next = ST_STORED_DROP;
                    end
                    state_next = S_STORE;
                end
                else
                begin
                    last_video_next = stamp_reg;
                    if (total_reg == '0)
                    begin
                        status_next = ST_EMPTY;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        lo_next    = '0;
                        hi_next    = total_reg;
                        state_next = S_PROBE;
                    end
                end
            end
            S_STORE:
            begin
                total_next = total_reg + CW'(1);
                state_next = S_DONE;
            end
            S_PROBE:
            begin
                // mid read issued here in every probe; compare follows while the range is still open
                if (lo_reg < hi_reg)
                begin
                    diff_next  = {{(64-CW){1'b0}}, mid};
                    state_next = S_CMP;
                end
                else
                begin
                    state_next = S_PICK;
                end
            end
            S_CMP:
            begin
                // no borrow means entry time is at or before the frame
                if (!sub_res[63])
                begin
                    lo_next = diff_reg[CW-1:0] + CW'(1);
                end
                else
                begin
                    hi_next = diff_reg[CW-1:0];
                end
                state_next = S_PROBE;
            end
            S_PICK:
            begin
                if (lo_reg == '0)
                begin
                    status_next = ST_NONE_EARLIER;
                    state_next  = S_DONE;
                end
                else
                begin
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                diff_next  = sub_res;
                state_next = S_WIN;
            end
            S_WIN:
            begin
                if (below)
                begin
                    status_next     = ST_MATCHED;
                    res_handle_next = rd_handle;
                    res_stamp_next  = rd_stamp;
                    oldest_next     = slot;
                    total_next      = total_reg - lo_reg;
                end
                else
                begin
                    status_next = ST_TOO_FAR;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            oldest_reg     <= '0;
            total_reg      <= '0;
            lo_reg         <= '0;
            hi_reg         <= '0;
            last_lane_reg  <= '0;
            last_video_reg <= '0;
            out_valid_reg  <= 1'b0;
            lane_gap_reg   <= RST_LANE_GAP;
            video_gap_reg  <= RST_VIDEO_GAP;
            window_reg     <= RST_MATCH_WIN;
            limit_reg      <= RST_QUEUE_LIMIT;
        end
        else
        begin
            state_reg      <= state_next;
            oldest_reg     <= oldest_next;
            total_reg      <= total_next;
            lo_reg         <= lo_next;
            hi_reg         <= hi_next;
            last_lane_reg  <= last_lane_next;
            last_video_reg <= last_video_next;
            out_valid_reg  <= out_valid_next;
            if (cfg.valid)
            begin
                case (cfg.index)
                    REG_LANE_GAP:    lane_gap_reg  <= cfg.data[GAP_W-1:0];
                    REG_VIDEO_GAP:   video_gap_reg <= cfg.data[GAP_W-1:0];
                    REG_MATCH_WIN:   window_reg    <= cfg.data[GAP_W-1:0];
                    REG_QUEUE_LIMIT: limit_reg     <= cfg.data[LIMIT_W-1:0];
                    default:         ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        stamp_reg      <= stamp_next;
        handle_reg     <= handle_next;
        diff_reg       <= diff_next;
        status_reg     <= status_next;
        res_handle_reg <= res_handle_next;
        res_stamp_reg  <= res_stamp_next;
        if (out_load)
        begin
            out_status_reg <= status_reg;
            out_handle_reg <= res_handle_reg;
            out_stamp_reg  <= res_stamp_reg;
            out_held_reg   <= HELD_W'(total_reg);
        end
    end

endmodule

// File: test/timestamp_match_queue_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timestamp_match_queue_checker
// Watches the request, result and register channels of the match queue. It
// keeps its own copy of the lane queue and the settings, works out the
// result of every accepted request and compares it with what comes out.
// ----------------------------------------------------------------------------
module timestamp_match_queue_checker
#(
    parameter int QUEUE_DEPTH = tmq_pkg::DEFAULT_QUEUE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    tmq_in_if    item,
    tmq_out_if   result,
    tmq_cfg_if   cfg,
    output int   mismatches,
    output int   awaiting,
    output int   checked,
    output int   matched
);
    import tmq_pkg::*;

    typedef struct packed {
        status_t           status;
        handle_t           handle;
        stamp_t            stamp;
        logic [HELD_W-1:0] held;
    } outcome_t;

    outcome_t outcome_q[$];

    logic [GAP_W-1:0]   lane_gap;
    logic [GAP_W-1:0]   video_gap;
    logic [GAP_W-1:0]   window;
    logic [LIMIT_W-1:0] limit_reg;

    logic [63:0] last_lane;
    logic [63:0] last_video;
    stamp_t      slot_stamp  [QUEUE_DEPTH];
    handle_t     slot_handle [QUEUE_DEPTH];
    int unsigned head;
    int unsigned held;

    // an item is early if it goes back in time or comes within the gap
    function automatic bit is_early(logic [63:0] now, logic [63:0] prev,
                                    logic [GAP_W-1:0] gap);
        if (now < prev)
            return 1'b1;
        return (now - prev) < {32'd0, gap};
    endfunction

    function automatic int unsigned kept_max();
        int unsigned lim;
        lim = 32'(limit_reg);
        if (lim < 1)
            lim = 1;
        if (lim > QUEUE_DEPTH)
            lim = QUEUE_DEPTH;
        return lim;
    endfunction

    function automatic outcome_t pair_request(logic cmd, stamp_t stamp, handle_t hnd);
        outcome_t    v;
        int unsigned n_le;
        int unsigned pos;
        logic [63:0] s64;
        logic [63:0] diff;
        v   = '0;
        s64 = {1'b0, stamp};
        if (cmd == CMD_LANE)
        begin
            if (is_early(s64, last_lane, lane_gap))
                v.status = ST_LANE_SOON;
            else
            begin
                last_lane = s64;
                v.status  = ST_STORED;
                if (held >= kept_max())
                begin
                    head     = (head + 1) % QUEUE_DEPTH;
                    held     = held - 1;
                    v.status = ST_STORED_DROP;
                end
                pos              = (head + held) % QUEUE_DEPTH;
                slot_stamp[pos]  = stamp;
                slot_handle[pos] = hnd;
                held             = held + 1;
            end
        end
        else if (is_early(s64, last_video, video_gap))
            v.status = ST_VIDEO_SOON;
        else
        begin
            last_video = s64;
            if (held == 0)
                v.status = ST_EMPTY;
            else
            begin
                // entries are in time order, so this is the count at or before the frame
                n_le = 0;
                for (int unsigned k = 0; k < held; k++)
                    if (slot_stamp[(head + k) % QUEUE_DEPTH] <= stamp)
                        n_le = k + 1;
                if (n_le == 0)
                    v.status = ST_NONE_EARLIER;
                else
                begin
                    pos  = (head + n_le - 1) % QUEUE_DEPTH;
                    diff = s64 - {1'b0, slot_stamp[pos]};
                    if (diff < {32'd0, window})
                    begin
                        v.status = ST_MATCHED;
                        v.handle = slot_handle[pos];
                        v.stamp  = slot_stamp[pos];
                        head     = (head + n_le) % QUEUE_DEPTH;
                        held     = held - n_le;
                    end
                    else
                        v.status = ST_TOO_FAR;
                end
            end
        end
        v.held = held[HELD_W-1:0];
        return v;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t want;
        if (!rst_n)
        begin
            lane_gap   = RST_LANE_GAP;
            video_gap  = RST_VIDEO_GAP;
            window     = RST_MATCH_WIN;
            limit_reg  = RST_QUEUE_LIMIT;
            last_lane  = '0;
            last_video = '0;
            head       = 0;
            held       = 0;
            outcome_q.delete();
            mismatches = 0;
            awaiting   = 0;
            checked    = 0;
            matched    = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_LANE_GAP:    lane_gap  = cfg.data;
                    REG_VIDEO_GAP:   video_gap = cfg.data;
                    REG_MATCH_WIN:   window    = cfg.data;
                    REG_QUEUE_LIMIT: limit_reg = cfg.data[LIMIT_W-1:0];
                    default: ;
                endcase
            end
            if (item.valid && item.ready)
                outcome_q = {outcome_q, pair_request(item.command, item.stamp_ns,
                                                     item.payload_handle)};
            if (result.valid && result.ready)
            begin
                if (outcome_q.size() == 0)
                begin
                    $display("%0t: result with no request waiting: status %0d held %0d",
                             $time, result.status, result.entries_held);
                    mismatches++;
                end
                else
                begin
                    want = outcome_q[0];
                    outcome_q.delete(0);
                    checked++;
                    if (want.status == ST_MATCHED)
                        matched++;
                    if (result.status !== want.status)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, result.status);
                        mismatches++;
                    end
                    if (result.match_handle !== want.handle)
                    begin
                        $display("%0t: match_handle expected %h actual %h",
                                 $time, want.handle, result.match_handle);
                        mismatches++;
                    end
                    if (result.match_stamp_ns !== want.stamp)
                    begin
                        $display("%0t: match_stamp_ns expected %0d actual %0d",
                                 $time, want.stamp, result.match_stamp_ns);
                        mismatches++;
                    end
                    if (result.entries_held !== want.held)
                    begin
                        $display("%0t: entries_held expected %0d actual %0d",
                                 $time, want.held, result.entries_held);
                        mismatches++;
                    end
                end
            end
            awaiting = outcome_q.size();
        end
    end

endmodule

// File: test/timestamp_match_queue_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timestamp_match_queue_tb
// Drives lane and video requests and register writes into the match queue
// with random idle gaps on both sides. A directed opening walks every status
// code and the limit cases of the settings; random phases then run streams
// of lane and frame times under several settings, ending at the top of the
// stamp range. Checking is done by the checker instance.
// ----------------------------------------------------------------------------
module timestamp_match_queue_tb;
    import tmq_pkg::*;

    localparam int          RUN_LIMIT = 500000;
    localparam int          TAIL      = 50;
    localparam logic [63:0] MS        = 64'd1_000_000;
    localparam logic [63:0] HIGH_BASE = 64'h7FFF_FFF0_0000_0000;
    localparam logic [63:0] STAMP_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   mismatches;
    int   awaiting;
    int   checked;
    int   matched;
    int   cycles = 0;
    int   sent = 0;
    int   settings = 0;
    bit   calm = 1'b0;

    logic [63:0]      lane_t = '0;
    logic [63:0]      video_t = '0;
    logic [GAP_W-1:0] lane_gap_v = RST_LANE_GAP;
    logic [GAP_W-1:0] video_gap_v = RST_VIDEO_GAP;

    always #5 clk = ~clk;

    tmq_in_if  item_ch();
    tmq_out_if result_ch();
    tmq_cfg_if cfg_ch();

    timestamp_match_queue dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    timestamp_match_queue_checker pairing_check
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item_ch),
        .result     (result_ch),
        .cfg        (cfg_ch),
        .mismatches (mismatches),
        .awaiting   (awaiting),
        .checked    (checked),
        .matched    (matched)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= RUN_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // mostly short pauses, now and then a long one
    function automatic int pause_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // result side back-pressure
    initial
    begin
        int stall;
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            result_ch.ready <= 1'b1;
            if (!calm && $urandom_range(0, 2) == 0)
            begin
                stall = pause_len();
                if (stall > 0)
                begin
                    @(negedge clk);
                    result_ch.ready <= 1'b0;
                    repeat (stall) @(negedge clk);
                end
            end
        end
    end

    task automatic send(input logic cmd, input logic [63:0] stamp, input handle_t hnd);
        int g;
        g = calm ? 0 : pause_len();
        if (g > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        item_ch.valid          <= 1'b1;
        item_ch.command        <= cmd;
        item_ch.stamp_ns       <= stamp[STAMP_W-1:0];
        item_ch.payload_handle <= hnd;
        do @(posedge clk); while (!item_ch.ready);
        @(negedge clk);
        sent++;
    endtask

    // hold off new requests until every result is back
    task automatic settle();
        item_ch.valid <= 1'b0;
        while (awaiting != 0)
            @(negedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input cfg_data_t value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic configure(input logic [GAP_W-1:0] lane_gap, input logic [GAP_W-1:0] video_gap,
                             input logic [GAP_W-1:0] window, input logic [LIMIT_W-1:0] limit);
        settle();
        write_reg(REG_LANE_GAP, lane_gap);
        write_reg(REG_VIDEO_GAP, video_gap);
        write_reg(REG_MATCH_WIN, window);
        write_reg(REG_QUEUE_LIMIT, {22'd0, limit});
        lane_gap_v  = lane_gap;
        video_gap_v = video_gap;
        calm        = ($urandom_range(0, 3) == 0);
        settings++;
    endtask

    // lane messages at roughly the lane rate, frames trailing the newest lane
    // time by a random lag, a few stale requests mixed in
    task automatic run_stream(input int count, input logic [63:0] extra_span,
                              input logic [63:0] lag_span);
        int          r;
        logic [63:0] step;
        logic [63:0] lag;
        logic [63:0] cand;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 8)
                send(1'($urandom_range(0, 1)), rand64() % (lane_t + 1), 16'($urandom()));
            else if (r < 55)
            begin
                if ($urandom_range(0, 9) == 0)
                    step = rand64() % ({32'd0, lane_gap_v} + 1);
                else
                    step = {32'd0, lane_gap_v} + rand64() % (extra_span + 1);
                lane_t = lane_t + step;
                send(CMD_LANE, lane_t, 16'($urandom()));
            end
            else
            begin
                lag  = rand64() % (lag_span + 1);
                cand = (lane_t > lag) ? lane_t - lag : 64'd0;
                if (cand <= video_t)
                    cand = video_t + rand64() % ({31'd0, video_gap_v, 1'b0} + 2);
                video_t = cand;
                send(CMD_VIDEO, video_t, 16'($urandom()));
            end
        end
    endtask

    initial
    begin
        item_ch.valid          = 1'b0;
        item_ch.command        = CMD_LANE;
        item_ch.stamp_ns       = '0;
        item_ch.payload_handle = '0;
        cfg_ch.valid           = 1'b0;
        cfg_ch.index           = REG_LANE_GAP;
        cfg_ch.data            = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: time zero is too soon, then every status code but stored with drop
        send(CMD_LANE, 0, 16'h1234);
        send(CMD_VIDEO, 0, 16'h0000);
        send(CMD_VIDEO, 10 * MS, 16'h0000);
        send(CMD_LANE, 100 * MS, 16'h0000);
        send(CMD_LANE, 120 * MS, 16'h5555);
        send(CMD_LANE, 50 * MS, 16'hAAAA);
        send(CMD_LANE, 200 * MS, 16'hFFFF);
        send(CMD_VIDEO, 50 * MS, 16'h0000);
        send(CMD_VIDEO, 52 * MS, 16'h0000);
        send(CMD_VIDEO, 600 * MS, 16'h0000);
        send(CMD_LANE, 700 * MS, 16'hABCD);
        send(CMD_VIDEO, 750 * MS, 16'h0000);
        send(CMD_VIDEO, 1000 * MS, 16'h0000);

        // zero gaps take equal times, limit of zero keeps one, zero window never matches
        configure(32'd0, 32'd0, 32'd0, 10'd0);
        send(CMD_LANE, 1000 * MS, 16'h0F0F);
        send(CMD_LANE, 1000 * MS, 16'hF0F0);
        send(CMD_VIDEO, 1000 * MS, 16'h0000);

        // widest gaps, narrowest window, limit above the depth
        configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 10'h3FF);
        send(CMD_LANE, 1000 * MS + 64'hFFFF_FFFF, 16'h8001);
        send(CMD_LANE, 1000 * MS + 64'h1_FFFF_FFFD, 16'h7FFE);
        send(CMD_VIDEO, 1000 * MS + 64'hFFFF_FFFF, 16'h0000);
        lane_t  = 1000 * MS + 64'h1_FFFF_FFFD;
        video_t = 1000 * MS + 64'hFFFF_FFFF;

        configure(RST_LANE_GAP, RST_VIDEO_GAP, RST_MATCH_WIN, 10'd8);
        run_stream(60, 30 * MS, 400 * MS);

        configure(32'd0, 32'd0, 32'd1000, 10'h3FF);
        run_stream(80, 500, 3000);

        for (int p = 0; p < 5; p++)
        begin
            configure($urandom_range(0, 100000), $urandom_range(0, 50000),
                      $urandom_range(0, 1000000), 10'($urandom_range(1, 6)));
            run_stream(40, 200000, 2000000);
        end

        // fill, then lower the limit below the count held and push more lane items
        configure(32'd0, 32'd0, 32'd0, 10'd40);
        repeat (30)
        begin
            lane_t = lane_t + $urandom_range(1, 100);
            send(CMD_LANE, lane_t, 16'($urandom()));
        end
        configure(32'd0, 32'd0, 32'd0, 10'd4);
        repeat (6)
        begin
            lane_t = lane_t + $urandom_range(1, 100);
            send(CMD_LANE, lane_t, 16'($urandom()));
        end
        video_t = (lane_t - 50 > video_t) ? lane_t - 50 : video_t;
        send(CMD_VIDEO, video_t, 16'h0000);
        configure(32'd0, 32'd0, 32'hFFFF_FFFF, 10'd4);
        video_t = (lane_t > video_t) ? lane_t : video_t;
        send(CMD_VIDEO, video_t, 16'h0000);
        run_stream(20, 100, 200);

        configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 10'd16);
        run_stream(40, 1000 * MS, 64'd8_000_000_000);

        // top of the stamp range
        configure(32'd1000, 32'd1000, 32'd1000000, 10'd512);
        lane_t  = HIGH_BASE;
        video_t = HIGH_BASE;
        run_stream(50, 100000, 2000000);
        send(CMD_LANE, STAMP_MAX, 16'hFFFF);
        send(CMD_VIDEO, STAMP_MAX, 16'h0000);

        settle();
        repeat (TAIL) @(negedge clk);
        $display("covered %0d requests under %0d register settings, up to the largest stamp",
                 sent, settings);
        $display("%0d results compared, %0d of them frame matches", checked, matched);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
